>>> sv/tfr_pkg.sv
// Shared request and response types and operation codes for the tagged FIFO with reclaim.
package tfr_pkg;

    localparam int VALUE_FIELD_W = 64;
    localparam int TAG_W         = 32;
    localparam int FUNC_W        = 3;
    localparam int COUNT_W       = 5;

    localparam logic [FUNC_W-1:0] FUNC_PUSH     = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP      = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_PEEK     = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CONTAINS = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_RECLAIM  = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [VALUE_FIELD_W-1:0] value;
        logic [TAG_W-1:0]         tag;
    } tfr_req_t;

    typedef struct packed {
        logic                     ok;
        logic [VALUE_FIELD_W-1:0] out_value;
        logic [TAG_W-1:0]         out_tag;
        logic [COUNT_W-1:0]       count;
    } tfr_rsp_t;

endpackage

>>> sv/tagged_fifo_with_reclaim_top.sv
// Top level of the tagged FIFO with reclaim: a linked-list queue kept in on-chip memories.
//
// The s_ channel carries one request per handshake: push a value and tag, pop the head,
// peek at the head, test whether a value is queued, or reclaim (unlink) the first queued
// entry holding a value. The m_ channel returns exactly one response per request, in
// request order, with a success flag, the value and tag read by pop or peek, and the
// number of queued entries after the request.
// Push, pop, peek, and any request that fails at once go from the idle state to the
// finishing step: acceptance issues the memory accesses, and the finishing step completes
// the update and loads the response register. Contains walks the list one entry per cycle
// up to the match (or through the whole queue when there is none); reclaim of a match
// passes through a release step that puts the entry on the free list. The walk is bounded
// by the single read port of the value store.
// After reset the queue is empty and every entry is free; no initialization sweep is
// run, so requests are taken as soon as reset is released. Links of entries never
// handed out are derived from a high-water mark instead of being stored.
// A request may be accepted while the previous response still waits on the m_ channel;
// the block then holds in its finishing step until the response register frees up, and
// it does not accept another request until then.
module tagged_fifo_with_reclaim_top #(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tfr_pkg::tfr_req_t s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output tfr_pkg::tfr_rsp_t m_payload
);
    import tfr_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int DAT_W = VALUE_WIDTH + TAG_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WALK = 4'b0010,
        ST_REL  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    // Successor of an index in the initial free-list chain.
    function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] r;
        if (i == IDX_W'(CAPACITY - 1)) begin
            r = '0;
        end else begin
            r = i + 1'b1;
        end
        return r;
    endfunction

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       head_reg, head_next;
    logic [IDX_W-1:0]       tail_reg, tail_next;
    logic [IDX_W-1:0]       free_head_reg, free_head_next;
    logic [CNT_W-1:0]       queued_reg, queued_next;
    logic [CNT_W-1:0]       hwm_reg, hwm_next;
    logic [IDX_W-1:0]       cur_reg, cur_next;
    logic [IDX_W-1:0]       prev_reg, prev_next;
    logic [CNT_W-1:0]       step_reg, step_next;
    logic [FUNC_W-1:0]      func_reg, func_next;
    logic [VALUE_WIDTH-1:0] key_reg, key_next;
    logic                   ok_reg, ok_next;
    logic                   fresh_reg, fresh_next;
    logic                   m_valid_reg, m_valid_next;
    tfr_rsp_t               m_payload_reg, m_payload_next;

    // Entry store: value and tag of each entry, and the link of each entry.
    logic [DAT_W-1:0] dat_mem [CAPACITY];
    logic [IDX_W-1:0] lnk_mem [CAPACITY];
    logic [DAT_W-1:0] dat_rd_reg;
    logic [IDX_W-1:0] lnk_rd_reg;

    logic             dat_we, dat_re, lnk_we, lnk_re;
    logic [IDX_W-1:0] dat_waddr, dat_raddr, lnk_waddr, lnk_raddr, lnk_wdata;
    logic [DAT_W-1:0] dat_wdata;

    logic                   accept, out_free, full, empty, last_step;
    logic [IDX_W-1:0]       link_eff;
    logic [VALUE_WIDTH-1:0] key_in, val_q;
    logic [TAG_W-1:0]       tag_q;
    tfr_rsp_t               rsp;

    // No request is taken while reset is held.
    assign s_ready   = aresetn && (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign full      = (queued_reg == CNT_W'(CAPACITY));
    assign empty     = (queued_reg == '0);
    assign last_step = (step_reg == queued_reg - CNT_W'(1));
    assign key_in    = s_payload.value[VALUE_WIDTH-1:0];
    assign val_q     = dat_rd_reg[VALUE_WIDTH-1:0];
    assign tag_q     = dat_rd_reg[DAT_W-1 -: TAG_W];
    // An entry at or above the high-water mark was never handed out, so its link is
    // still the one from the reset chain.
    assign link_eff  = fresh_reg ? inc_idx(cur_reg) : lnk_rd_reg;

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_head_next = free_head_reg;
        queued_next    = queued_reg;
        hwm_next       = hwm_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        step_next      = step_reg;
        func_next      = func_reg;
        key_next       = key_reg;
        ok_next        = ok_reg;
        fresh_next     = fresh_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;

        dat_we    = 1'b0;
        dat_waddr = '0;
        dat_wdata = '0;
        dat_re    = 1'b0;
        dat_raddr = '0;
        lnk_we    = 1'b0;
        lnk_waddr = '0;
        lnk_wdata = '0;
        lnk_re    = 1'b0;
        lnk_raddr = '0;
        rsp       = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    func_next  = s_payload.func;
                    key_next   = key_in;
                    ok_next    = 1'b0;
                    fresh_next = 1'b0;
                    state_next = ST_FIN;
                    case (s_payload.func)
                        FUNC_PUSH: begin
                            if (!full) begin
                                ok_next    = 1'b1;
                                dat_we     = 1'b1;
                                dat_waddr  = free_head_reg;
                                dat_wdata  = {s_payload.tag, key_in};
                                lnk_re     = 1'b1;
                                lnk_raddr  = free_head_reg;
                                cur_next   = free_head_reg;
                                fresh_next = (CNT_W'(free_head_reg) >= hwm_reg);
                                if (!empty) begin
                                    lnk_we    = 1'b1;
                                    lnk_waddr = tail_reg;
                                    lnk_wdata = free_head_reg;
                                end
                            end
                        end
                        FUNC_POP, FUNC_PEEK: begin
                            if (!empty) begin
                                ok_next    = 1'b1;
                                dat_re     = 1'b1;
                                dat_raddr  = head_reg;
                                lnk_re     = 1'b1;
                                lnk_raddr  = head_reg;
                                cur_next   = head_reg;
                                fresh_next = (CNT_W'(head_reg) >= hwm_reg);
                            end
                        end
                        FUNC_CONTAINS, FUNC_RECLAIM: begin
                            if (!empty) begin
                                dat_re     = 1'b1;
                                dat_raddr  = head_reg;
                                lnk_re     = 1'b1;
                                lnk_raddr  = head_reg;
                                cur_next   = head_reg;
                                prev_next  = head_reg;
                                step_next  = '0;
                                fresh_next = (CNT_W'(head_reg) >= hwm_reg);
                                state_next = ST_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_WALK: begin
                if (val_q == key_reg) begin
                    ok_next = 1'b1;
                    if (func_reg == FUNC_RECLAIM) begin
                        // Unlink the match here; its return to the free list
                        // needs its own link write in the next cycle.
                        if (step_reg != '0) begin
                            lnk_we    = 1'b1;
                            lnk_waddr = prev_reg;
                            lnk_wdata = link_eff;
                        end else begin
                            head_next = link_eff;
                        end
                        if (last_step) begin
                            tail_next = prev_reg;
                        end
                        queued_next = queued_reg - CNT_W'(1);
                        state_next  = ST_REL;
                    end else begin
                        state_next = ST_FIN;
                    end
                end else if (last_step) begin
                    state_next = ST_FIN;
                end else begin
                    prev_next  = cur_reg;
                    cur_next   = link_eff;
                    step_next  = step_reg + CNT_W'(1);
                    dat_re     = 1'b1;
                    dat_raddr  = link_eff;
                    lnk_re     = 1'b1;
                    lnk_raddr  = link_eff;
                    fresh_next = (CNT_W'(link_eff) >= hwm_reg);
                end
            end

            ST_REL: begin
                lnk_we         = 1'b1;
                lnk_waddr      = cur_reg;
                lnk_wdata      = free_head_reg;
                free_head_next = cur_reg;
                state_next     = ST_FIN;
            end

            ST_FIN: begin
                if (out_free) begin
                    rsp.ok = ok_reg;
                    if (ok_reg) begin
                        case (func_reg)
                            FUNC_PUSH: begin
                                free_head_next = link_eff;
                                if (fresh_reg) begin
                                    hwm_next = hwm_reg + CNT_W'(1);
                                end
                                tail_next = cur_reg;
                                if (empty) begin
                                    head_next = cur_reg;
                                end
                                queued_next = queued_reg + CNT_W'(1);
                            end
                            FUNC_POP: begin
                                rsp.out_value  = VALUE_FIELD_W'(val_q);
                                rsp.out_tag    = tag_q;
                                head_next      = link_eff;
                                queued_next    = queued_reg - CNT_W'(1);
                                lnk_we         = 1'b1;
                                lnk_waddr      = cur_reg;
                                lnk_wdata      = free_head_reg;
                                free_head_next = cur_reg;
                            end
                            FUNC_PEEK: begin
                                rsp.out_value = VALUE_FIELD_W'(val_q);
                                rsp.out_tag   = tag_q;
                            end
                            default: begin
                            end
                        endcase
                    end
                    rsp.count      = COUNT_W'(queued_next);
                    m_payload_next = rsp;
                    m_valid_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (dat_we) begin
            dat_mem[dat_waddr] <= dat_wdata;
        end
        if (dat_re) begin
            dat_rd_reg <= dat_mem[dat_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (lnk_we) begin
            lnk_mem[lnk_waddr] <= lnk_wdata;
        end
        if (lnk_re) begin
            lnk_rd_reg <= lnk_mem[lnk_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            free_head_reg <= '0;
            queued_reg    <= '0;
            hwm_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_head_reg <= free_head_next;
            queued_reg    <= queued_next;
            hwm_reg       <= hwm_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        step_reg      <= step_next;
        func_reg      <= func_next;
        key_reg       <= key_next;
        ok_reg        <= ok_next;
        fresh_reg     <= fresh_next;
        m_payload_reg <= m_payload_next;
    end

endmodule

>>> sv/tfr_checker.sv
// Port-level checker for the tagged FIFO with reclaim, bound to its top level.
module tfr_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input tfr_pkg::tfr_rsp_t m_payload
);
    import tfr_pkg::*;

    // A stalled response keeps its contents.
    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("response changed while stalled");

    // No response is offered right after reset.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("response valid after reset");

    // A failed request reads nothing back.
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_payload.ok |-> m_payload.out_value == '0 && m_payload.out_tag == '0)
        else $error("failed request returned data");

    // Requests are processed one at a time: after an accept the input closes.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while one is in progress");

endmodule

bind tagged_fifo_with_reclaim_top tfr_checker u_tfr_checker (.*);

>>> sim/tagged_fifo_with_reclaim_top_tb.sv
// Self-checking testbench for the tagged FIFO with reclaim, driven by request and response handshakes.
module tagged_fifo_with_reclaim_top_tb;
    import tfr_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 64;
    localparam logic [VALUE_FIELD_W-1:0] VALUE_MASK =
        {VALUE_FIELD_W{1'b1}} >> (VALUE_FIELD_W - VALUE_WIDTH);
    // Codes past reclaim are not operations; the block must answer them with a failure.
    localparam logic [FUNC_W-1:0] FUNC_RESERVED_FIRST = FUNC_RECLAIM + 3'd1;
    localparam int MAX_REPORTS = 10;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    tfr_req_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    tfr_rsp_t  m_payload;

    tagged_fifo_with_reclaim_top #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of the linked-list store: queued entries and the free list.
    logic [VALUE_FIELD_W-1:0] ent_value [CAPACITY];
    logic [TAG_W-1:0]         ent_tag   [CAPACITY];
    logic [3:0]               ent_link  [CAPACITY];
    logic [3:0]               q_head;
    logic [3:0]               q_tail;
    logic [3:0]               fl_head;
    logic [4:0]               fl_count;
    logic [4:0]               q_count;

    tfr_rsp_t                 expected_rsp [$];
    logic [VALUE_FIELD_W-1:0] value_pool [8];
    int                       send_idle_pct = 14;
    int                       recv_idle_pct = 47;
    int                       error_count   = 0;

    function automatic void reset_shadow();
        for (int i = 0; i < CAPACITY; i++) begin
            ent_value[i] = '0;
            ent_tag[i]   = '0;
            ent_link[i]  = 4'(i + 1);
        end
        q_head   = '0;
        q_tail   = '0;
        fl_head  = '0;
        fl_count = 5'(CAPACITY);
        q_count  = '0;
    endfunction

    function automatic void free_entry(input logic [3:0] slot);
        ent_link[slot] = fl_head;
        fl_head        = slot;
        fl_count       = fl_count + 5'd1;
    endfunction

    // Applies one request to the shadow store and returns the response it must produce.
    function automatic tfr_rsp_t apply_request(input tfr_req_t r);
        tfr_rsp_t                 rsp;
        logic [VALUE_FIELD_W-1:0] v;
        logic [3:0]               slot;
        logic [3:0]               cur;
        logic [3:0]               prev;
        bit                       found;
        rsp   = '0;
        v     = r.value & VALUE_MASK;
        found = 1'b0;
        case (r.func)
            FUNC_PUSH: begin
                if (fl_count > 0) begin
                    slot            = fl_head;
                    fl_head         = ent_link[slot];
                    fl_count        = fl_count - 5'd1;
                    ent_value[slot] = v;
                    ent_tag[slot]   = r.tag;
                    if (q_count == 0)
                        q_head = slot;
                    else
                        ent_link[q_tail] = slot;
                    q_tail  = slot;
                    q_count = q_count + 5'd1;
                    rsp.ok  = 1'b1;
                end
            end
            FUNC_POP, FUNC_PEEK: begin
                if (q_count > 0) begin
                    slot          = q_head;
                    rsp.out_value = ent_value[slot];
                    rsp.out_tag   = ent_tag[slot];
                    rsp.ok        = 1'b1;
                    if (r.func == FUNC_POP) begin
                        q_head  = ent_link[slot];
                        q_count = q_count - 5'd1;
                        free_entry(slot);
                    end
                end
            end
            FUNC_CONTAINS, FUNC_RECLAIM: begin
                cur  = q_head;
                prev = cur;
                for (int i = 0; i < q_count && !found; i++) begin
                    if (ent_value[cur] == v) begin
                        found  = 1'b1;
                        rsp.ok = 1'b1;
                        if (r.func == FUNC_RECLAIM) begin
                            if (i == 0)
                                q_head = ent_link[cur];
                            else
                                ent_link[prev] = ent_link[cur];
                            // Unlinking the last entry moves the tail back by one.
                            if (i + 1 == q_count)
                                q_tail = prev;
                            ent_value[cur] = '0;
                            ent_tag[cur]   = '0;
                            q_count        = q_count - 5'd1;
                            free_entry(cur);
                        end
                    end else begin
                        prev = cur;
                        cur  = ent_link[cur];
                    end
                end
            end
            default: begin
            end
        endcase
        rsp.count = q_count;
        return rsp;
    endfunction

    function automatic tfr_req_t make_req(input logic [FUNC_W-1:0] f,
                                          input logic [VALUE_FIELD_W-1:0] v,
                                          input logic [TAG_W-1:0] t);
        tfr_req_t r;
        r.func  = f;
        r.value = v;
        r.tag   = t;
        return r;
    endfunction

    function automatic logic [VALUE_FIELD_W-1:0] random_value();
        return {$urandom, $urandom};
    endfunction

    // Holds the request on the s_ channel until it is taken, idling first at random.
    task automatic send_req(input tfr_req_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= r;
        do
            @(posedge aclk);
        while (!s_ready);
        expected_rsp.push_back(apply_request(r));
    endtask

    task automatic note_error(input string what, input logic [VALUE_FIELD_W-1:0] exp_v,
                              input logic [VALUE_FIELD_W-1:0] act_v);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch in %s: expected %h, got %h", what, exp_v, act_v);
    endtask

    task automatic check_response(input tfr_rsp_t got);
        tfr_rsp_t exp_rsp;
        if (expected_rsp.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("response %h arrived with no request outstanding", got);
        end else begin
            exp_rsp = expected_rsp.pop_front();
            if (got.ok !== exp_rsp.ok)
                note_error("ok", VALUE_FIELD_W'(exp_rsp.ok), VALUE_FIELD_W'(got.ok));
            if (got.out_value !== exp_rsp.out_value)
                note_error("out_value", exp_rsp.out_value, got.out_value);
            if (got.out_tag !== exp_rsp.out_tag)
                note_error("out_tag", VALUE_FIELD_W'(exp_rsp.out_tag),
                           VALUE_FIELD_W'(got.out_tag));
            if (got.count !== exp_rsp.count)
                note_error("count", VALUE_FIELD_W'(exp_rsp.count), VALUE_FIELD_W'(got.count));
        end
    endtask

    // Response side: random back-pressure and a check of every response taken.
    always @(posedge aclk) begin
        if (aresetn) begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_valid && m_ready)
                check_response(m_payload);
        end
    end

    // Every read-type request on an empty queue must fail, as must the unused codes.
    task automatic test_empty_queue();
        send_req(make_req(FUNC_POP, random_value(), $urandom));
        send_req(make_req(FUNC_PEEK, random_value(), $urandom));
        send_req(make_req(FUNC_CONTAINS, '0, '0));
        send_req(make_req(FUNC_RECLAIM, '0, '0));
        for (int k = 0; k < 3; k++)
            send_req(make_req(FUNC_W'(FUNC_RESERVED_FIRST + k), random_value(), $urandom));
    endtask

    // Fill the store with extreme values, overflow it, search the middle, then unlink at tail and head.
    task automatic test_fill_and_reclaim();
        logic [VALUE_FIELD_W-1:0] fill_val [CAPACITY];
        fill_val[0] = '0;
        fill_val[1] = '1;
        fill_val[2] = {VALUE_FIELD_W/2{2'b10}};
        fill_val[3] = {VALUE_FIELD_W/2{2'b01}};
        for (int i = 4; i < CAPACITY; i++)
            fill_val[i] = random_value();
        send_req(make_req(FUNC_PUSH, fill_val[0], '0));
        send_req(make_req(FUNC_PUSH, fill_val[1], '1));
        send_req(make_req(FUNC_PUSH, fill_val[2], {TAG_W/2{2'b10}}));
        send_req(make_req(FUNC_PUSH, fill_val[3], {TAG_W/2{2'b01}}));
        for (int i = 4; i < CAPACITY; i++)
            send_req(make_req(FUNC_PUSH, fill_val[i], $urandom));
        send_req(make_req(FUNC_PUSH, random_value(), $urandom));
        send_req(make_req(FUNC_CONTAINS, fill_val[CAPACITY/2], $urandom));
        send_req(make_req(FUNC_RECLAIM, fill_val[CAPACITY-1], $urandom));
        send_req(make_req(FUNC_RECLAIM, fill_val[0], $urandom));
        send_req(make_req(FUNC_PEEK, '0, '0));
    endtask

    // Random traffic whose push share swings so the queue keeps running full and empty.
    task automatic test_random_traffic(input int n_items, input int s_pct, input int r_pct);
        tfr_req_t            r;
        int                  push_pct;
        int                  pick;
        logic [FUNC_W-1:0]   f;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        push_pct      = 70;
        for (int n = 0; n < n_items; n++) begin
            if (n % 40 == 39)
                push_pct = (push_pct == 70) ? 25 : 70;
            if ($urandom_range(99) < 3) begin
                f = FUNC_W'(FUNC_RESERVED_FIRST + $urandom_range(2));
            end else if ($urandom_range(99) < push_pct) begin
                f = FUNC_PUSH;
            end else begin
                pick = $urandom_range(9);
                if (pick < 4)
                    f = FUNC_POP;
                else if (pick < 5)
                    f = FUNC_PEEK;
                else if (pick < 7)
                    f = FUNC_CONTAINS;
                else
                    f = FUNC_RECLAIM;
            end
            // A small pool of values makes duplicates and search hits common.
            r.func  = f;
            r.value = ($urandom_range(3) == 0) ? random_value() : value_pool[$urandom_range(7)];
            r.tag   = $urandom;
            send_req(r);
        end
    endtask

    initial begin
        value_pool[0] = '0;
        value_pool[1] = '1;
        for (int i = 2; i < 8; i++)
            value_pool[i] = random_value();
        reset_shadow();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_queue();
        test_fill_and_reclaim();
        test_random_traffic(410, 14, 47);
        test_random_traffic(410, 47, 14);
        test_random_traffic(410, 0, 0);
        s_valid <= 1'b0;

        while (expected_rsp.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (error_count == 0 && expected_rsp.size() == 0)
            $display("PASS tagged_fifo_with_reclaim_top");
        else
            $display("FAIL tagged_fifo_with_reclaim_top");
        $finish;
    end

    // Guard against a hung handshake; the slowest correct run needs far less than this.
    initial begin
        #3000000;
        $display("FAIL tagged_fifo_with_reclaim_top");
        $finish;
    end

endmodule
